[hdl/cprp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cprp_pkg
// Byte codes and status codes for the cursor position report parser.
// ----------------------------------------------------------------------------
package cprp_pkg;

   // received byte codes of a cursor position report
   localparam logic [7:0] BYTE_ESC  = 8'h1B;
   localparam logic [7:0] BYTE_LSQ  = 8'h5B;
   localparam logic [7:0] BYTE_SEMI = 8'h3B;
   localparam logic [7:0] BYTE_R    = 8'h52;
   localparam logic [7:0] BYTE_ZERO = 8'h30;
   localparam logic [7:0] BYTE_NINE = 8'h39;

   // decimal radix of the coordinate digits
   localparam int unsigned RADIX = 10;

   // reply status codes
   typedef enum logic {
      STATUS_OK        = 1'b0,
      STATUS_MALFORMED = 1'b1
   } status_type;

endpackage : cprp_pkg
`default_nettype wire

[hdl/cursor_position_report_parser_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cursor_position_report_parser_unit
// Parses ESC '[' row ';' col 'R' replies one received byte per word.
// Results are registered: valid in the cycle after a reply ends or breaks.
// Throughput: 1 word per cycle while the result register is empty or taken;
// the phase and accumulator update is a single registered step.
// Reset: synchronous; phase to expect ESC, accumulators, swap, rsp valid to 0.
// ----------------------------------------------------------------------------
module cursor_position_report_parser_unit #(
   parameter int unsigned COORD_BITS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   // configuration write
   input  wire logic csr_valid,
   output logic      csr_ready,
   input  wire logic csr_data,     // swap_axes
   // request stream
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,  // [7:0] rx_byte
   input  wire logic       req_tuser,  // [0] restart
   // response stream
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   // [C:0] pos_row, [2C+1:C+1] cursor_col, [2C+9:2C+2] bad_byte, zero pad
   output logic [((2*(COORD_BITS+1)+8+7)/8)*8-1:0] rsp_tdata,
   output cprp_pkg::status_type rsp_tuser   // [0] reply_status
);

   import cprp_pkg::*;

   localparam int unsigned OUT_W   = COORD_BITS + 1;
   localparam int unsigned FIELD_W = 2*OUT_W + 8;
   localparam int unsigned TDATA_W = ((FIELD_W + 7)/8)*8;
   localparam int unsigned SUM_W   = COORD_BITS + 4;
   localparam logic [COORD_BITS-1:0] COORD_MAX = '1;

   typedef enum logic [1:0] {
      PH_ESC = 2'd0,
      PH_LSQ = 2'd1,
      PH_ROW = 2'd2,
      PH_COL = 2'd3
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [COORD_BITS-1:0]  row_ff, row_in;
   logic [COORD_BITS-1:0]  col_ff, col_in;
   logic                   swap_ff;
   logic                   rsp_valid_ff;
   logic [TDATA_W-1:0]     rsp_data_ff, rsp_data_in;
   status_type             rsp_user_ff, rsp_user_in;

   phase_type              phase_cur;
   logic [COORD_BITS-1:0]  row_cur, col_cur;
   logic [COORD_BITS-1:0]  row_acc, col_acc;
   logic [SUM_W-1:0]       row_sum, col_sum;
   logic [3:0]             digit;
   logic                   is_digit;
   logic                   byte_ok, reply_done, emit;
   logic [COORD_BITS-1:0]  first_val, second_val;
   logic [OUT_W-1:0]       row_out, col_out;
   logic                   req_fire;

   // handshakes
   assign csr_ready  = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // restart clears the parse before this byte is looked at
   assign phase_cur = req_tuser ? PH_ESC : phase_ff;
   assign row_cur   = req_tuser ? '0 : row_ff;
   assign col_cur   = req_tuser ? '0 : col_ff;

   // decimal digit accumulate: acc*10 + digit, saturating
   assign is_digit = (req_tdata >= BYTE_ZERO) && (req_tdata <= BYTE_NINE);
   assign digit    = 4'(req_tdata - BYTE_ZERO);
   assign row_sum  = (SUM_W'(row_cur) << 3) + (SUM_W'(row_cur) << 1) + SUM_W'(digit);
   assign col_sum  = (SUM_W'(col_cur) << 3) + (SUM_W'(col_cur) << 1) + SUM_W'(digit);
   assign row_acc  = (row_sum > SUM_W'(COORD_MAX)) ? COORD_MAX : row_sum[COORD_BITS-1:0];
   assign col_acc  = (col_sum > SUM_W'(COORD_MAX)) ? COORD_MAX : col_sum[COORD_BITS-1:0];

   // phase decode of the current byte
   always_comb begin
      phase_in   = phase_cur;
      row_in     = row_cur;
      col_in     = col_cur;
      byte_ok    = 1'b0;
      reply_done = 1'b0;
      case (phase_cur)
         PH_ESC: begin
            if (req_tdata == BYTE_ESC) begin
               byte_ok  = 1'b1;
               phase_in = PH_LSQ;
            end
         end
         PH_LSQ: begin
            if (req_tdata == BYTE_LSQ) begin
               byte_ok  = 1'b1;
               phase_in = PH_ROW;
            end
         end
         PH_ROW: begin
            if (is_digit) begin
               byte_ok = 1'b1;
               row_in  = row_acc;
            end else if (req_tdata == BYTE_SEMI) begin
               byte_ok  = 1'b1;
               phase_in = PH_COL;
            end
         end
         PH_COL: begin
            if (is_digit) begin
               byte_ok = 1'b1;
               col_in  = col_acc;
            end else if (req_tdata == BYTE_R) begin
               byte_ok    = 1'b1;
               reply_done = 1'b1;
            end
         end
         default: begin
            byte_ok = 1'b0;
         end
      endcase
      // any result sends the parser back to expect ESC
      if (!byte_ok || reply_done) begin
         phase_in = PH_ESC;
         row_in   = '0;
         col_in   = '0;
      end
   end

   assign emit = !byte_ok || reply_done;

   // swap and make zero-based
   assign first_val  = swap_ff ? col_cur : row_cur;
   assign second_val = swap_ff ? row_cur : col_cur;
   assign row_out    = {1'b0, first_val} - OUT_W'(1);
   assign col_out    = {1'b0, second_val} - OUT_W'(1);

   // result word
   always_comb begin
      if (!byte_ok) begin
         rsp_data_in = TDATA_W'({req_tdata, {OUT_W{1'b0}}, {OUT_W{1'b0}}});
         rsp_user_in = STATUS_MALFORMED;
      end else begin
         rsp_data_in = TDATA_W'({8'h00, col_out, row_out});
         rsp_user_in = STATUS_OK;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_ESC;
         row_ff       <= '0;
         col_ff       <= '0;
         swap_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            swap_ff <= csr_data;
         end
         if (req_fire) begin
            phase_ff <= phase_in;
            row_ff   <= row_in;
            col_ff   <= col_in;
         end
         if (req_fire) begin
            rsp_valid_ff <= emit;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (req_fire && emit) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   // checks
   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_ESC) |-> (row_ff == '0 && col_ff == '0))
      else $error("accumulators not clear while expecting ESC");

   a_result_resets_phase: assert property (@(posedge clock) disable iff (reset)
      (req_fire && emit) |=> (phase_ff == PH_ESC))
      else $error("phase not back to ESC after a result");

   a_ok_no_bad_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_user_ff == STATUS_OK) |-> (rsp_data_ff[2*OUT_W +: 8] == 8'h00))
      else $error("complete reply carries a bad byte");

   a_bad_zero_coords: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_user_ff == STATUS_MALFORMED) |-> (rsp_data_ff[2*OUT_W-1:0] == '0))
      else $error("malformed reply carries coordinates");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_valid_ff)
      else $error("request stalled with empty result register");

endmodule : cursor_position_report_parser_unit
`default_nettype wire
